// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the two-finger touch smoother.
// Each macro wraps one concurrent assertion clocked by clk with reset rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define TFTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies another condition in the next cycle.
`define TFTS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/tfts_pkg.sv
// Package of the two-finger touch smoother: codes, widths and sequencer states.
// Used by tfts_iter and two_finger_touch_smoother; depends on nothing.
`default_nettype none

package tfts_pkg;

  localparam int CoordBits   = 16;
  localparam int AttBits     = 9;
  localparam int FrameBits   = 32;
  localparam int MaxInsertDef = 16;

  // Shared iterative unit: operand shift register and result widths.
  localparam int IterSrcW  = 34;
  localparam int IterRemW  = 20;
  localparam int IterResW  = 24;
  localparam int IterStepW = 6;
  localparam int SqrtSteps = IterSrcW / 2;
  localparam int SpaceBits = SqrtSteps;

  localparam int InDataW  = 136;
  localparam int OutDataW = 104;

  localparam logic [1:0] FUNC_NONE   = 2'd0;
  localparam logic [1:0] FUNC_SINGLE = 2'd1;
  localparam logic [1:0] FUNC_TWO    = 2'd2;
  localparam logic [1:0] FUNC_HANDS  = 2'd3;

  localparam logic [1:0] MODE_STAY   = 2'd0;
  localparam logic [1:0] MODE_IDLE   = 2'd1;
  localparam logic [1:0] MODE_SINGLE = 2'd2;
  localparam logic [1:0] MODE_HANDS  = 2'd3;

  localparam logic EV_POSITION = 1'b0;
  localparam logic EV_RELEASE  = 1'b1;

  localparam logic [2:0] REG_DEAD_ZONE  = 3'd0;
  localparam logic [2:0] REG_PINCH      = 3'd1;
  localparam logic [2:0] REG_IDLE_TO    = 3'd2;
  localparam logic [2:0] REG_SINGLE_TO  = 3'd3;
  localparam logic [2:0] REG_HANDS_TO   = 3'd4;
  localparam logic [2:0] REG_INSERT_CNT = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_SQRT_OLD,
    ST_SQRT_OLD_WAIT,
    ST_SQRT_CUR,
    ST_SQRT_CUR_WAIT,
    ST_EV_MUL,
    ST_EV_DIV,
    ST_EV_WAIT,
    ST_EV_EMIT,
    ST_EMIT_ONE,
    ST_EMIT_REL
  } seq_state_t;

  typedef struct packed {
    logic                 start;
    logic                 sqrt_mode;
    logic [IterStepW-1:0] steps;
  } iter_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

endpackage

`default_nettype wire

// File: rtl/tfts_iter.sv
// Shared restoring unit: integer square root or unsigned division, one digit a cycle.
// Depends on tfts_pkg for widths and the request and status structs.
`default_nettype none

module tfts_iter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire tfts_pkg::iter_req_t               req,
  input  wire logic [tfts_pkg::IterSrcW-1:0]     operand,
  input  wire logic [tfts_pkg::IterRemW-1:0]     divisor,
  output tfts_pkg::iter_stat_t                   stat,
  output logic [tfts_pkg::IterResW-1:0]          result
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic                              sqrt_r, sqrt_nxt;
  logic [tfts_pkg::IterStepW-1:0]    cnt_r, cnt_nxt;
  logic [tfts_pkg::IterSrcW-1:0]     src_r, src_nxt;
  logic [tfts_pkg::IterRemW-1:0]     rem_r, rem_nxt;
  logic [tfts_pkg::IterRemW-1:0]     div_r, div_nxt;
  logic [tfts_pkg::IterResW-1:0]     res_r, res_nxt;
  logic [tfts_pkg::IterRemW-1:0]     rem_sh;
  logic [tfts_pkg::IterRemW-1:0]     trial;
  logic                              ge;

  always_comb begin
    // In square root mode two operand bits enter per step and the trial
    // subtrahend is the partial root with 01 appended.
    if (sqrt_r) begin
      rem_sh = {rem_r[tfts_pkg::IterRemW-3:0],
                src_r[tfts_pkg::IterSrcW-1:tfts_pkg::IterSrcW-2]};
      trial  = {res_r[tfts_pkg::IterRemW-3:0], 2'b01};
    end else begin
      rem_sh = {rem_r[tfts_pkg::IterRemW-2:0], src_r[tfts_pkg::IterSrcW-1]};
      trial  = div_r;
    end
    ge = (rem_sh >= trial);

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sqrt_nxt = sqrt_r;
    cnt_nxt  = cnt_r;
    src_nxt  = src_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    res_nxt  = res_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      sqrt_nxt = req.sqrt_mode;
      cnt_nxt  = req.steps;
      src_nxt  = operand;
      rem_nxt  = '0;
      div_nxt  = divisor;
      res_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh - trial) : rem_sh;
      res_nxt = {res_r[tfts_pkg::IterResW-2:0], ge};
      src_nxt = sqrt_r ? {src_r[tfts_pkg::IterSrcW-3:0], 2'b00}
                       : {src_r[tfts_pkg::IterSrcW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == tfts_pkg::IterStepW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sqrt_r <= sqrt_nxt;
    cnt_r  <= cnt_nxt;
    src_r  <= src_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    res_r  <= res_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = res_r;

endmodule

`default_nettype wire

// File: rtl/two_finger_touch_smoother.sv
// Top level of the two-finger touch smoother: sequencer, state and channels.
// Depends on tfts_pkg, tfts_iter and assert_macros.svh.
//
//   channel  direction  signals                          transfer when
//   in_      slave      in_tvalid/tready/tdata/tuser     in_tvalid && in_tready
//   out_     master     out_tvalid/tready/tdata/tuser/   out_tvalid && out_tready
//                       tlast
//   cfg_     slave      cfg_valid/ready/index/data       cfg_valid && cfg_ready
//
// A frame is taken only while the sequencer is idle. A two-finger frame with
// history computes nine squares through one 16x16 multiplier and two square
// roots in the shared iterative unit; a frame that moves or pinches then adds
// n events with four divisions per event. A stalled output holds the sequencer
// in its emit state. Reset is synchronous and gives the register defaults.
`default_nettype none
`include "assert_macros.svh"

module two_finger_touch_smoother #(
  parameter int MAX_INSERT = tfts_pkg::MaxInsertDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // in_tdata from bit 0: frame_id[32], tip1_x, tip1_y, tip2_x, tip2_y [16 each],
  // tip1_orient, tip1_angle, tip2_orient, tip2_angle [9 each], zero fill
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [tfts_pkg::InDataW-1:0]  in_tdata,
  // in_tuser from bit 0: func[2]
  input  wire logic [1:0]                    in_tuser,
  // out_tdata from bit 0: out1_x, out1_y, out2_x, out2_y [16 each], out1_orient,
  // out1_angle, out2_orient, out2_angle [9 each], next_mode[2], zero fill
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [tfts_pkg::OutDataW-1:0]      out_tdata,
  // out_tuser from bit 0: event_kind[1]
  output logic [0:0]                         out_tuser,
  output logic                               out_tlast,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [15:0]                   cfg_data
);

  localparam int CntW = $clog2(MAX_INSERT + 1);
  localparam int NumW = tfts_pkg::CoordBits + CntW;
  localparam int CW   = tfts_pkg::CoordBits;
  localparam int AW   = tfts_pkg::AttBits;
  localparam int FW   = tfts_pkg::FrameBits;
  localparam int SW   = tfts_pkg::SpaceBits;

  tfts_pkg::seq_state_t state_r, state_nxt;

  // Configuration registers.
  logic [15:0] dz_r, dz_nxt;
  logic [15:0] pt_r, pt_nxt;
  logic [7:0]  ito_r, ito_nxt;
  logic [7:0]  sto_r, sto_nxt;
  logic [7:0]  hto_r, hto_nxt;
  logic [4:0]  ic_r, ic_nxt;

  // Latched frame; c_r holds the current points (snapped during the check).
  logic [1:0]    func_r, func_nxt;
  logic [FW-1:0] frame_r, frame_nxt;
  logic [CW-1:0] c_r [4];
  logic [CW-1:0] c_nxt [4];
  logic [AW-1:0] att_r [4];
  logic [AW-1:0] att_nxt [4];

  // History.
  logic [CW-1:0] held_r [4];
  logic [CW-1:0] held_nxt [4];
  logic [AW-1:0] hatt_r [4];
  logic [AW-1:0] hatt_nxt [4];
  logic [FW-1:0] last_r, last_nxt;
  logic          valid_r, valid_nxt;

  // Working registers of the sequencer.
  logic [3:0]        t_r, t_nxt;
  logic [2*CW-1:0]   prod_r, prod_nxt;
  logic [2*CW:0]     acc_r, acc_nxt;
  logic [2*CW-1:0]   dz2_r, dz2_nxt;
  logic [2*CW:0]     sqold_r, sqold_nxt;
  logic [SW-1:0]     spold_r, spold_nxt;
  logic              move_r, move_nxt;
  logic [CntW-1:0]   n_r, n_nxt;
  logic [CntW-1:0]   ind_r, ind_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [NumW-1:0]   num_r, num_nxt;
  logic              neg_r, neg_nxt;
  logic [CW-1:0]     ev_r [4];
  logic [CW-1:0]     ev_nxt [4];

  // Output register.
  logic                          ov_r, ov_nxt;
  logic [tfts_pkg::OutDataW-1:0] od_r, od_nxt;
  logic                          ou_r, ou_nxt;
  logic                          ol_r, ol_nxt;

  tfts_pkg::iter_req_t              it_req;
  tfts_pkg::iter_stat_t             it_stat;
  logic [tfts_pkg::IterSrcW-1:0]    it_operand;
  logic [tfts_pkg::IterResW-1:0]    it_result;

  tfts_iter u_iter (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (it_req),
    .operand (it_operand),
    .divisor (tfts_pkg::IterRemW'(n_r)),
    .stat    (it_stat),
    .result  (it_result)
  );

  // Combinational helpers.
  logic [CW-1:0]   op_a, op_b, op_d;
  logic [2*CW:0]   sum;
  logic [FW-1:0]   elapsed;
  logic [7:0]      limit;
  logic [SW-1:0]   spcur, spdiff;
  logic            pinch;
  logic [CntW-1:0] n_calc;
  logic [CW:0]     dsig;
  logic [CW-1:0]   dmag;
  logic [CW-1:0]   quot;
  logic            out_free;

  function automatic logic [tfts_pkg::OutDataW-1:0] pack_out(
    input logic [CW-1:0] p0, input logic [CW-1:0] p1,
    input logic [CW-1:0] p2, input logic [CW-1:0] p3,
    input logic [AW-1:0] a0, input logic [AW-1:0] a1,
    input logic [AW-1:0] a2, input logic [AW-1:0] a3,
    input logic [1:0] mode);
    pack_out = {2'b00, mode, a3, a2, a1, a0, p3, p2, p1, p0};
  endfunction

  always_comb begin
    // Operand pair of the square term t: dead zone, the two tip moves, the
    // old spacing and finally the spacing of the snapped current points.
    unique case (t_r)
      4'd0:    begin op_a = dz_r;      op_b = '0;        end
      4'd1:    begin op_a = c_r[0];    op_b = held_r[0]; end
      4'd2:    begin op_a = c_r[1];    op_b = held_r[1]; end
      4'd3:    begin op_a = c_r[2];    op_b = held_r[2]; end
      4'd4:    begin op_a = c_r[3];    op_b = held_r[3]; end
      4'd5:    begin op_a = held_r[0]; op_b = held_r[2]; end
      4'd6:    begin op_a = held_r[1]; op_b = held_r[3]; end
      4'd7:    begin op_a = c_r[0];    op_b = c_r[2];    end
      default: begin op_a = c_r[1];    op_b = c_r[3];    end
    endcase
    op_d = (op_a > op_b) ? (op_a - op_b) : (op_b - op_a);
    sum  = acc_r + {1'b0, prod_r};

    elapsed = frame_r - last_r;
    unique case (func_r)
      tfts_pkg::FUNC_NONE:   limit = ito_r;
      tfts_pkg::FUNC_SINGLE: limit = sto_r;
      default:               limit = hto_r;
    endcase

    spcur  = it_result[SW-1:0];
    spdiff = (spcur > spold_r) ? (spcur - spold_r) : (spold_r - spcur);
    pinch  = (spdiff > SW'(pt_r));

    if (ic_r == 5'd0) begin
      n_calc = CntW'(1);
    end else if (7'(ic_r) > 7'(MAX_INSERT)) begin
      n_calc = CntW'(MAX_INSERT);
    end else begin
      n_calc = CntW'(ic_r);
    end

    dsig = {1'b0, c_r[k_r]} - {1'b0, held_r[k_r]};
    dmag = dsig[CW] ? CW'(-dsig) : dsig[CW-1:0];
    quot = it_result[CW-1:0];

    out_free = !ov_r || out_tready;

    it_req.start     = 1'b0;
    it_req.sqrt_mode = 1'b1;
    it_req.steps     = tfts_pkg::IterStepW'(tfts_pkg::SqrtSteps);
    it_operand       = {1'b0, sqold_r};

    state_nxt = state_r;
    dz_nxt  = dz_r;  pt_nxt  = pt_r;  ito_nxt = ito_r;
    sto_nxt = sto_r; hto_nxt = hto_r; ic_nxt  = ic_r;
    func_nxt  = func_r;
    frame_nxt = frame_r;
    c_nxt     = c_r;
    att_nxt   = att_r;
    held_nxt  = held_r;
    hatt_nxt  = hatt_r;
    last_nxt  = last_r;
    valid_nxt = valid_r;
    t_nxt     = t_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    dz2_nxt   = dz2_r;
    sqold_nxt = sqold_r;
    spold_nxt = spold_r;
    move_nxt  = move_r;
    n_nxt     = n_r;
    ind_nxt   = ind_r;
    k_nxt     = k_r;
    num_nxt   = num_r;
    neg_nxt   = neg_r;
    ev_nxt    = ev_r;
    ov_nxt    = out_tready ? 1'b0 : ov_r;
    od_nxt    = od_r;
    ou_nxt    = ou_r;
    ol_nxt    = ol_r;

    if (cfg_valid) begin
      unique case (cfg_index)
        tfts_pkg::REG_DEAD_ZONE:  dz_nxt  = cfg_data;
        tfts_pkg::REG_PINCH:      pt_nxt  = cfg_data;
        tfts_pkg::REG_IDLE_TO:    ito_nxt = cfg_data[7:0];
        tfts_pkg::REG_SINGLE_TO:  sto_nxt = cfg_data[7:0];
        tfts_pkg::REG_HANDS_TO:   hto_nxt = cfg_data[7:0];
        tfts_pkg::REG_INSERT_CNT: ic_nxt  = cfg_data[4:0];
        default: ;
      endcase
    end

    unique case (state_r)
      tfts_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          func_nxt   = in_tuser;
          frame_nxt  = in_tdata[31:0];
          c_nxt[0]   = in_tdata[47:32];
          c_nxt[1]   = in_tdata[63:48];
          c_nxt[2]   = in_tdata[79:64];
          c_nxt[3]   = in_tdata[95:80];
          att_nxt[0] = in_tdata[104:96];
          att_nxt[1] = in_tdata[113:105];
          att_nxt[2] = in_tdata[122:114];
          att_nxt[3] = in_tdata[131:123];
          state_nxt  = tfts_pkg::ST_DISPATCH;
        end
      end
      tfts_pkg::ST_DISPATCH: begin
        if (func_r != tfts_pkg::FUNC_TWO) begin
          state_nxt = (elapsed > FW'(limit)) ? tfts_pkg::ST_EMIT_REL : tfts_pkg::ST_IDLE;
        end else if (!valid_r) begin
          state_nxt = tfts_pkg::ST_EMIT_ONE;
        end else begin
          t_nxt     = '0;
          move_nxt  = 1'b0;
          state_nxt = tfts_pkg::ST_SQ_MUL;
        end
      end
      tfts_pkg::ST_SQ_MUL: begin
        prod_nxt  = op_d * op_d;
        state_nxt = tfts_pkg::ST_SQ_ACC;
      end
      tfts_pkg::ST_SQ_ACC: begin
        case (t_r)
          4'd0: dz2_nxt = prod_r;
          4'd2: begin
            // Tip 1 inside the dead zone snaps back to its held position.
            if (sum < {1'b0, dz2_r}) begin
              c_nxt[0] = held_r[0];
              c_nxt[1] = held_r[1];
            end else begin
              move_nxt = 1'b1;
            end
          end
          4'd4: begin
            if (sum < {1'b0, dz2_r}) begin
              c_nxt[2] = held_r[2];
              c_nxt[3] = held_r[3];
            end else begin
              move_nxt = 1'b1;
            end
          end
          4'd6: sqold_nxt = sum;
          4'd8: acc_nxt = sum;
          default: acc_nxt = {1'b0, prod_r};
        endcase
        if (t_r == 4'd8) begin
          state_nxt = tfts_pkg::ST_SQRT_OLD;
        end else begin
          t_nxt     = t_r + 1'b1;
          state_nxt = tfts_pkg::ST_SQ_MUL;
        end
      end
      tfts_pkg::ST_SQRT_OLD: begin
        it_req.start = 1'b1;
        state_nxt    = tfts_pkg::ST_SQRT_OLD_WAIT;
      end
      tfts_pkg::ST_SQRT_OLD_WAIT: begin
        if (it_stat.done) begin
          spold_nxt = it_result[SW-1:0];
          state_nxt = tfts_pkg::ST_SQRT_CUR;
        end
      end
      tfts_pkg::ST_SQRT_CUR: begin
        it_req.start = 1'b1;
        it_operand   = {1'b0, acc_r};
        state_nxt    = tfts_pkg::ST_SQRT_CUR_WAIT;
      end
      tfts_pkg::ST_SQRT_CUR_WAIT: begin
        if (it_stat.done) begin
          if (pinch || move_r) begin
            n_nxt     = n_calc;
            ind_nxt   = n_calc - 1'b1;
            k_nxt     = '0;
            state_nxt = tfts_pkg::ST_EV_MUL;
          end else begin
            state_nxt = tfts_pkg::ST_EMIT_ONE;
          end
        end
      end
      tfts_pkg::ST_EV_MUL: begin
        num_nxt   = NumW'(ind_r * dmag);
        neg_nxt   = dsig[CW];
        state_nxt = tfts_pkg::ST_EV_DIV;
      end
      tfts_pkg::ST_EV_DIV: begin
        it_req.start     = 1'b1;
        it_req.sqrt_mode = 1'b0;
        it_req.steps     = tfts_pkg::IterStepW'(NumW);
        it_operand       = {num_r, (tfts_pkg::IterSrcW - NumW)'(0)};
        state_nxt        = tfts_pkg::ST_EV_WAIT;
      end
      tfts_pkg::ST_EV_WAIT: begin
        if (it_stat.done) begin
          // The quotient is truncated toward zero, so it moves back from the
          // current point by its magnitude against the sign of the move.
          ev_nxt[k_r] = neg_r ? (c_r[k_r] + quot) : (c_r[k_r] - quot);
          if (k_r == 2'd3) begin
            state_nxt = tfts_pkg::ST_EV_EMIT;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = tfts_pkg::ST_EV_MUL;
          end
        end
      end
      tfts_pkg::ST_EV_EMIT: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          od_nxt = pack_out(ev_r[0], ev_r[1], ev_r[2], ev_r[3],
                            att_r[0], att_r[1], att_r[2], att_r[3],
                            tfts_pkg::MODE_STAY);
          ou_nxt = tfts_pkg::EV_POSITION;
          ol_nxt = (ind_r == '0);
          if (ind_r == '0) begin
            held_nxt  = c_r;
            hatt_nxt  = att_r;
            last_nxt  = frame_r;
            state_nxt = tfts_pkg::ST_IDLE;
          end else begin
            ind_nxt   = ind_r - 1'b1;
            k_nxt     = '0;
            state_nxt = tfts_pkg::ST_EV_MUL;
          end
        end
      end
      tfts_pkg::ST_EMIT_ONE: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          // Without history the frame itself goes out; with history the
          // held points and attitudes go out once.
          if (valid_r) begin
            od_nxt = pack_out(held_r[0], held_r[1], held_r[2], held_r[3],
                              hatt_r[0], hatt_r[1], hatt_r[2], hatt_r[3],
                              tfts_pkg::MODE_STAY);
          end else begin
            od_nxt = pack_out(c_r[0], c_r[1], c_r[2], c_r[3],
                              att_r[0], att_r[1], att_r[2], att_r[3],
                              tfts_pkg::MODE_STAY);
          end
          ou_nxt    = tfts_pkg::EV_POSITION;
          ol_nxt    = 1'b1;
          held_nxt  = c_r;
          hatt_nxt  = att_r;
          last_nxt  = frame_r;
          valid_nxt = 1'b1;
          state_nxt = tfts_pkg::ST_IDLE;
        end
      end
      tfts_pkg::ST_EMIT_REL: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          unique case (func_r)
            tfts_pkg::FUNC_NONE:   od_nxt = {2'b00, tfts_pkg::MODE_IDLE, 100'd0};
            tfts_pkg::FUNC_SINGLE: od_nxt = {2'b00, tfts_pkg::MODE_SINGLE, 100'd0};
            default:               od_nxt = {2'b00, tfts_pkg::MODE_HANDS, 100'd0};
          endcase
          // A release out of single or two-hand touch restarts the timeout.
          if (func_r != tfts_pkg::FUNC_NONE) begin
            last_nxt = frame_r;
          end
          ou_nxt    = tfts_pkg::EV_RELEASE;
          ol_nxt    = 1'b1;
          valid_nxt = 1'b0;
          state_nxt = tfts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tfts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tfts_pkg::ST_IDLE;
      dz_r    <= 16'd80;
      pt_r    <= 16'd192;
      ito_r   <= 8'd4;
      sto_r   <= 8'd4;
      hto_r   <= 8'd4;
      ic_r    <= 5'd5;
      last_r  <= '0;
      valid_r <= 1'b0;
      ov_r    <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        held_r[i] <= '0;
        hatt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      dz_r    <= dz_nxt;
      pt_r    <= pt_nxt;
      ito_r   <= ito_nxt;
      sto_r   <= sto_nxt;
      hto_r   <= hto_nxt;
      ic_r    <= ic_nxt;
      last_r  <= last_nxt;
      valid_r <= valid_nxt;
      ov_r    <= ov_nxt;
      held_r  <= held_nxt;
      hatt_r  <= hatt_nxt;
    end
    func_r  <= func_nxt;
    frame_r <= frame_nxt;
    c_r     <= c_nxt;
    att_r   <= att_nxt;
    t_r     <= t_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    dz2_r   <= dz2_nxt;
    sqold_r <= sqold_nxt;
    spold_r <= spold_nxt;
    move_r  <= move_nxt;
    n_r     <= n_nxt;
    ind_r   <= ind_nxt;
    k_r     <= k_nxt;
    num_r   <= num_nxt;
    neg_r   <= neg_nxt;
    ev_r    <= ev_nxt;
    od_r    <= od_nxt;
    ou_r    <= ou_nxt;
    ol_r    <= ol_nxt;
  end

  assign in_tready    = (state_r == tfts_pkg::ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_tvalid   = ov_r;
  assign out_tdata    = od_r;
  assign out_tuser[0] = ou_r;
  assign out_tlast    = ol_r;

  // The shared unit must be quiet whenever a new frame can be taken.
  `TFTS_ASSERT(a_idle_unit_quiet, in_tready |-> !it_stat.busy, "unit busy while idle")
  // A release event always closes the run of its frame.
  `TFTS_ASSERT(a_release_last, (out_tvalid && out_tuser[0]) |-> out_tlast,
               "release without last")
  // A finished square root or division is only ever awaited in a wait state.
  `TFTS_ASSERT(a_done_in_wait, it_stat.done |-> (state_r == tfts_pkg::ST_SQRT_OLD_WAIT ||
               state_r == tfts_pkg::ST_SQRT_CUR_WAIT || state_r == tfts_pkg::ST_EV_WAIT),
               "unit result not awaited")
  // Starting the unit always makes it busy.
  `TFTS_ASSERT_NEXT(a_start_busy, it_req.start, it_stat.busy, "unit did not start")

endmodule

`default_nettype wire
